/* hdl/rtt_pkg.sv */
// Shared types and constants for the reduction tree task tracker.
// No dependencies; used by the top level and the testbench.
package rtt_pkg;

  localparam int MAX_WORKERS = 16;
  localparam int TIME_BITS   = 48;
  localparam int NODE_CAP    = 2 * MAX_WORKERS;
  localparam int TASK_CAP    = MAX_WORKERS;
  localparam int QUEUE_CAP   = 2 * MAX_WORKERS;

  localparam logic [2:0] CMD_MARK    = 3'd0;
  localparam logic [2:0] CMD_POP     = 3'd1;
  localparam logic [2:0] CMD_CLAIM   = 3'd2;
  localparam logic [2:0] CMD_FINISH  = 3'd3;
  localparam logic [2:0] CMD_REBUILD = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_BAD_ID  = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TASK = 2'd1;
  localparam logic [1:0] KIND_STOP = 2'd2;

  localparam logic [2:0] FLAG_QUEUED  = 3'b001;
  localparam logic [2:0] FLAG_CLAIMED = 3'b010;
  localparam logic [2:0] FLAG_DONE    = 3'b100;

  // parent marker for a node with no task above it (never below task_total)
  localparam logic [4:0] PARENT_NONE = 5'd16;
  localparam logic [5:0] NODE_NONE   = 6'd32;
  localparam logic [4:0] STOP_TOKEN  = 5'd16;

  typedef struct packed {
    logic [2:0]           cmd;
    logic [4:0]           item_id;
    logic [TIME_BITS-1:0] event_time;
  } rtt_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [1:0]           pop_kind;
    logic [3:0]           popped_task;
    logic [TIME_BITS-1:0] left_time;
    logic [TIME_BITS-1:0] right_time;
    logic                 tree_done;
    logic [TIME_BITS-1:0] done_time;
  } rtt_out_t;

endpackage

/* hdl/rtt_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module rtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/reduction_tree_task_tracker_top.sv */
// Reduction tree task tracker: command sequencer, tree tables and queue control.
// Depends on rtt_pkg and rtt_ram (node time store and ready queue store).
//
// Usage: one command beat on in_* (valid/ready) yields exactly one result beat
// on out_* (valid/ready). cfg_wr_en/cfg_wr_data set worker_count, used by the
// next rebuild; write it only while the block is idle.
// The block works on one command at a time; each kind of command goes through:
//   mark, finish without completion: table update, then enqueue check
//   completion: table update, then one stop token pushed per cycle, one per leaf
//   pop: queue memory read, claim: two reads through the
//   one read port of the node time memory, bad id or unknown command: result set on acceptance
//   rebuild: table clear, then pairing level by level, one pair a cycle
// The next command is taken the cycle after the result beat leaves.
// Reset: synchronous, active low; the tree is empty (all ids out of range)
// until a rebuild, worker_count returns to 16. Memories need no clearing:
// only written entries are read.
// Stall: a result waits in the output register while out_ready is low, and
// no new command is accepted until it is taken.
module reduction_tree_task_tracker_top
  import rtt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rtt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rtt_out_t out_data,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_ENQ, S_STOP, S_POP_RD, S_CLM_L, S_CLM_R, S_BUILD
  } state_t;

  state_t st_r;

  logic [4:0]           wc_r;
  logic [4:0]           node_total_r;
  logic [3:0]           task_total_r;
  logic [5:0]           root_node_r;
  logic [3:0]           root_task_r;
  logic                 fin_r;
  logic [TIME_BITS-1:0] ftime_r;
  logic [4:0]           qhead_r, qtail_r;
  logic [5:0]           qfill_r;

  logic [NODE_CAP-1:0]  ready_r;
  logic [4:0]           parent_r [NODE_CAP];
  logic [4:0]           tl_r     [TASK_CAP];
  logic [4:0]           tr_r     [TASK_CAP];
  logic [4:0]           to_r     [TASK_CAP];
  logic [2:0]           flags_r  [TASK_CAP];

  logic [4:0]           t_r;
  logic [3:0]           claim_r;
  logic [4:0]           stop_cnt_r;
  logic [TIME_BITS-1:0] lt_r;
  logic                 out_valid_r;
  rtt_out_t             out_data_r;

  // rebuild sequencer: current level is [b_s_r, b_s_r + b_k_r) plus optional carry
  logic [4:0] b_s_r, b_k_r, b_c_r, b_i_r, b_fo_r, b_pairs_r;
  logic       b_hc_r;

  logic                 in_acc;
  logic [4:0]           id;
  logic [3:0]           tidx;
  logic                 id_node_ok, id_task_ok, claim_ok;
  logic [5:0]           leaf6, cap6;
  logic [3:0]           tt;
  logic                 enq_go;
  logic                 push_req, q_we;
  logic [4:0]           push_val;
  logic [4:0]           q_rdata;
  logic                 nt_we;
  logic [4:0]           nt_waddr, nt_raddr;
  logic [TIME_BITS-1:0] nt_rdata;
  logic [4:0]           wc_sat;
  logic [5:0]           ncur, b_i_next;
  logic [4:0]           elem_a, elem_b, elem_last, elem_first;

  function automatic logic [4:0] elem(input logic [4:0] idx, input logic [4:0] s,
                                      input logic [4:0] k, input logic [4:0] c);
    elem = (idx < k) ? 5'(s + idx) : c;
  endfunction

  function automatic rtt_out_t mk_out(input logic [1:0] status, input logic [1:0] kind,
                                      input logic [3:0] popped,
                                      input logic [TIME_BITS-1:0] lt,
                                      input logic [TIME_BITS-1:0] rt,
                                      input logic fin, input logic [TIME_BITS-1:0] ft);
    rtt_out_t o;
    o.status      = status;
    o.pop_kind    = kind;
    o.popped_task = popped;
    o.left_time   = lt;
    o.right_time  = rt;
    o.tree_done   = fin;
    o.done_time   = ft;
    mk_out = o;
  endfunction

  assign in_ready  = (st_r == S_IDLE) && !out_valid_r;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign id         = in_data.item_id;
  assign tidx       = id[3:0];
  assign id_node_ok = id < node_total_r;
  assign id_task_ok = id < {1'b0, task_total_r};
  assign claim_ok   = (flags_r[tidx] == FLAG_QUEUED) &&
                      ready_r[tl_r[tidx]] && ready_r[tr_r[tidx]];

  assign leaf6 = (node_total_r == 5'd0) ? 6'd0 : 6'(({1'b0, node_total_r} + 6'd1) >> 1);
  always_comb begin
    cap6 = 6'({2'b00, task_total_r} + leaf6 + 6'd1);
    if (cap6 > 6'(QUEUE_CAP)) begin
      cap6 = 6'(QUEUE_CAP);
    end
  end

  assign tt     = t_r[3:0];
  assign enq_go = (t_r < {1'b0, task_total_r}) && (flags_r[tt] == 3'b000) &&
                  ready_r[tl_r[tt]] && ready_r[tr_r[tt]];

  always_comb begin
    push_req = 1'b0;
    push_val = STOP_TOKEN;
    if (st_r == S_ENQ) begin
      push_req = enq_go;
      push_val = {1'b0, tt};
    end else if (st_r == S_STOP) begin
      push_req = 1'b1;
    end
  end
  assign q_we = push_req && (qfill_r < cap6);

  assign nt_we    = in_acc && (((in_data.cmd == CMD_MARK) && id_node_ok) ||
                               ((in_data.cmd == CMD_FINISH) && id_task_ok));
  assign nt_waddr = (in_data.cmd == CMD_MARK) ? id : to_r[tidx];
  assign nt_raddr = (st_r == S_IDLE) ? tl_r[tidx] : tr_r[claim_r];

  assign wc_sat     = (wc_r > 5'(MAX_WORKERS)) ? 5'(MAX_WORKERS) : wc_r;
  assign ncur       = {1'b0, b_k_r} + {5'd0, b_hc_r};
  assign b_i_next   = {1'b0, b_i_r} + 6'd1;
  assign elem_a     = elem(b_i_r, b_s_r, b_k_r, b_c_r);
  assign elem_b     = elem(b_i_next[4:0], b_s_r, b_k_r, b_c_r);
  assign elem_last  = elem(5'(ncur - 6'd1), b_s_r, b_k_r, b_c_r);
  assign elem_first = elem(5'd0, b_s_r, b_k_r, b_c_r);

  rtt_ram #(.WIDTH(TIME_BITS), .DEPTH(NODE_CAP)) u_node_time (
    .clk   (clk),
    .we    (nt_we),
    .waddr (nt_waddr),
    .wdata (in_data.event_time),
    .raddr (nt_raddr),
    .rdata (nt_rdata)
  );

  rtt_ram #(.WIDTH(5), .DEPTH(QUEUE_CAP)) u_ready_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (qtail_r),
    .wdata (push_val),
    .raddr (qhead_r),
    .rdata (q_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      wc_r         <= 5'(MAX_WORKERS);
      node_total_r <= '0;
      task_total_r <= '0;
      root_node_r  <= NODE_NONE;
      root_task_r  <= '0;
      fin_r        <= 1'b0;
      ftime_r      <= '0;
      qhead_r      <= '0;
      qtail_r      <= '0;
      qfill_r      <= '0;
      ready_r      <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NODE_CAP; i++) begin
        parent_r[i] <= PARENT_NONE;
      end
      for (int i = 0; i < TASK_CAP; i++) begin
        flags_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        wc_r <= cfg_wr_data;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (q_we) begin
        qtail_r <= qtail_r + 5'd1;
        qfill_r <= qfill_r + 6'd1;
      end

      unique case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            priority case (in_data.cmd)
              CMD_MARK: begin
                if (!id_node_ok) begin
                  out_valid_r <= 1'b1;
                  out_data_r  <= mk_out(ST_BAD_ID, KIND_NONE, '0, '0, '0, fin_r, ftime_r);
                end else begin
                  ready_r[id] <= 1'b1;
                  if (task_total_r == 4'd0 && {1'b0, id} == root_node_r && !fin_r) begin
                    fin_r      <= 1'b1;
                    ftime_r    <= in_data.event_time;
                    stop_cnt_r <= leaf6[4:0];
                    st_r       <= S_STOP;
                  end else begin
                    t_r  <= parent_r[id];
                    st_r <= S_ENQ;
                  end
                end
              end
              CMD_POP: begin
                if (qfill_r == 6'd0) begin
                  out_valid_r <= 1'b1;
                  out_data_r  <= mk_out(ST_EMPTY, KIND_NONE, '0, '0, '0, fin_r, ftime_r);
                end else begin
                  // memory read of the head entry is already under way
                  qhead_r <= qhead_r + 5'd1;
                  qfill_r <= qfill_r - 6'd1;
                  st_r    <= S_POP_RD;
                end
              end
              CMD_CLAIM: begin
                if (!id_task_ok) begin
                  out_valid_r <= 1'b1;
                  out_data_r  <= mk_out(ST_BAD_ID, KIND_NONE, '0, '0, '0, fin_r, ftime_r);
                end else if (!claim_ok) begin
                  out_valid_r <= 1'b1;
                  out_data_r  <= mk_out(ST_REFUSED, KIND_NONE, '0, '0, '0, fin_r, ftime_r);
                end else begin
                  flags_r[tidx] <= FLAG_CLAIMED;
                  claim_r       <= tidx;
                  st_r          <= S_CLM_L;
                end
              end
              CMD_FINISH: begin
                if (!id_task_ok) begin
                  out_valid_r <= 1'b1;
                  out_data_r  <= mk_out(ST_BAD_ID, KIND_NONE, '0, '0, '0, fin_r, ftime_r);
                end else begin
                  flags_r[tidx]       <= flags_r[tidx] | FLAG_DONE;
                  ready_r[to_r[tidx]] <= 1'b1;
                  if (tidx == root_task_r && !fin_r) begin
                    fin_r      <= 1'b1;
                    ftime_r    <= in_data.event_time;
                    stop_cnt_r <= leaf6[4:0];
                    st_r       <= S_STOP;
                  end else begin
                    t_r  <= parent_r[to_r[tidx]];
                    st_r <= S_ENQ;
                  end
                end
              end
              CMD_REBUILD: begin
                ready_r <= '0;
                for (int i = 0; i < NODE_CAP; i++) begin
                  parent_r[i] <= PARENT_NONE;
                end
                for (int i = 0; i < TASK_CAP; i++) begin
                  flags_r[i] <= '0;
                end
                qhead_r      <= '0;
                qtail_r      <= '0;
                qfill_r      <= '0;
                node_total_r <= wc_sat;
                task_total_r <= '0;
                root_node_r  <= NODE_NONE;
                root_task_r  <= '0;
                fin_r        <= 1'b0;
                ftime_r      <= '0;
                b_s_r        <= '0;
                b_k_r        <= wc_sat;
                b_hc_r       <= 1'b0;
                b_c_r        <= '0;
                b_i_r        <= '0;
                b_fo_r       <= wc_sat;
                b_pairs_r    <= '0;
                st_r         <= S_BUILD;
              end
              default: begin
                out_valid_r <= 1'b1;
                out_data_r  <= mk_out(ST_REFUSED, KIND_NONE, '0, '0, '0, fin_r, ftime_r);
              end
            endcase
          end
        end
        S_ENQ: begin
          if (enq_go) begin
            flags_r[tt] <= FLAG_QUEUED;
          end
          out_valid_r <= 1'b1;
          out_data_r  <= mk_out(ST_OK, KIND_NONE, '0, '0, '0, fin_r, ftime_r);
          st_r        <= S_IDLE;
        end
        S_STOP: begin
          stop_cnt_r <= stop_cnt_r - 5'd1;
          if (stop_cnt_r == 5'd1) begin
            out_valid_r <= 1'b1;
            out_data_r  <= mk_out(ST_OK, KIND_NONE, '0, '0, '0, fin_r, ftime_r);
            st_r        <= S_IDLE;
          end
        end
        S_POP_RD: begin
          out_valid_r <= 1'b1;
          if (q_rdata == STOP_TOKEN) begin
            out_data_r <= mk_out(ST_OK, KIND_STOP, '0, '0, '0, fin_r, ftime_r);
          end else begin
            out_data_r <= mk_out(ST_OK, KIND_TASK, q_rdata[3:0], '0, '0, fin_r, ftime_r);
          end
          st_r <= S_IDLE;
        end
        S_CLM_L: begin
          lt_r <= nt_rdata;
          st_r <= S_CLM_R;
        end
        S_CLM_R: begin
          out_valid_r <= 1'b1;
          out_data_r  <= mk_out(ST_OK, KIND_NONE, '0, lt_r, nt_rdata, fin_r, ftime_r);
          st_r        <= S_IDLE;
        end
        S_BUILD: begin
          if (ncur == 6'd0) begin
            out_valid_r <= 1'b1;
            out_data_r  <= mk_out(ST_OK, KIND_NONE, '0, '0, '0, fin_r, ftime_r);
            st_r        <= S_IDLE;
          end else if (b_i_next < ncur) begin
            // pair two adjacent nodes into the next task
            tl_r[task_total_r]     <= elem_a;
            tr_r[task_total_r]     <= elem_b;
            to_r[task_total_r]     <= node_total_r;
            parent_r[elem_a]       <= {1'b0, task_total_r};
            parent_r[elem_b]       <= {1'b0, task_total_r};
            node_total_r           <= node_total_r + 5'd1;
            task_total_r           <= task_total_r + 4'd1;
            b_pairs_r              <= b_pairs_r + 5'd1;
            b_i_r                  <= 5'(b_i_r + 5'd2);
          end else if (ncur == 6'd1) begin
            root_node_r <= {1'b0, elem_first};
            root_task_r <= (task_total_r == 4'd0) ? 4'd0 : task_total_r - 4'd1;
            out_valid_r <= 1'b1;
            out_data_r  <= mk_out(ST_OK, KIND_NONE, '0, '0, '0, fin_r, ftime_r);
            st_r        <= S_IDLE;
          end else begin
            // advance to the next level, carry an odd last node up
            b_hc_r    <= ncur[0];
            b_c_r     <= elem_last;
            b_s_r     <= b_fo_r;
            b_k_r     <= b_pairs_r;
            b_fo_r    <= node_total_r;
            b_pairs_r <= '0;
            b_i_r     <= '0;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    qfill_r <= 6'(QUEUE_CAP))
    else $error("queue fill above capacity");

  a_ptr_fill: assert property (@(posedge clk) disable iff (!rst_n)
    5'(qtail_r - qhead_r) == qfill_r[4:0])
    else $error("queue pointers disagree with fill");

  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (st_r != S_IDLE) || out_valid_r)
    else $error("accepted command left no work and no result");

  a_push_state: assert property (@(posedge clk) disable iff (!rst_n)
    q_we |-> (st_r == S_ENQ) || (st_r == S_STOP))
    else $error("queue write outside enqueue or stop phase");

endmodule

/* tb/sv/reduction_tree_task_tracker_top_test.sv */
// Self-checking test of the reduction tree task tracker top level.
// Depends on rtt_pkg and reduction_tree_task_tracker_top; an inline tracker
// model predicts every result beat and a small scoreboard compares them.
`timescale 1ns / 1ps

module reduction_tree_task_tracker_top_test;
  import rtt_pkg::*;

  localparam int NODES = 2 * MAX_WORKERS;
  localparam logic [5:0] NO_PARENT = 6'd32;

  // command codes with no operation behind them
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  class tracker_board;
    rtt_out_t pending[$];
    int errors;

    // tracker state
    logic [4:0]           leaves_cfg;
    bit                   ready_bit[NODES];
    logic [TIME_BITS-1:0] ready_at[NODES];
    logic [5:0]           parent_of[NODES];
    logic [4:0]           left_of[MAX_WORKERS], right_of[MAX_WORKERS], out_of[MAX_WORKERS];
    logic [2:0]           flags[MAX_WORKERS];
    logic [4:0]           fifo[NODES];
    int                   head, tail, fill;
    int                   nodes, tasks, root_task;
    logic [5:0]           root_node;
    bit                   finished;
    logic [TIME_BITS-1:0] finished_at;

    function new();
      errors = 0;
      leaves_cfg = 5'd16;
      clear_tree();
    endfunction

    function void clear_tree();
      for (int i = 0; i < NODES; i++) begin
        ready_bit[i] = 0;
        ready_at[i] = '0;
        parent_of[i] = NO_PARENT;
      end
      for (int i = 0; i < MAX_WORKERS; i++) flags[i] = '0;
      head = 0; tail = 0; fill = 0;
      nodes = 0; tasks = 0; root_task = 0;
      root_node = NODE_NONE;
      finished = 0;
      finished_at = '0;
    endfunction

    function int leaves();
      return nodes == 0 ? 0 : (nodes + 1) / 2;
    endfunction

    function void push(logic [4:0] v);
      int cap;
      cap = tasks + leaves() + 1;
      if (cap > NODES) cap = NODES;
      if (fill >= cap) return;
      fifo[tail] = v;
      tail = (tail + 1) % NODES;
      fill++;
    endfunction

    function void try_queue(logic [5:0] t);
      if (t >= tasks) return;
      if (flags[t] != 0) return;
      if (!ready_bit[left_of[t]] || !ready_bit[right_of[t]]) return;
      flags[t] |= FLAG_QUEUED;
      push(t[4:0]);
    endfunction

    function void finish_tree(logic [TIME_BITS-1:0] tm);
      int n;
      n = leaves();
      finished = 1;
      finished_at = tm;
      for (int i = 0; i < n; i++) push(STOP_TOKEN);
    endfunction

    function void build_tree();
      int lvl[MAX_WORKERS], nxt[MAX_WORKERS];
      int cnt, ncnt, n;
      n = int'(leaves_cfg);
      if (n > MAX_WORKERS) n = MAX_WORKERS;
      clear_tree();
      if (n == 0) return;
      nodes = n;
      for (int i = 0; i < n; i++) lvl[i] = i;
      cnt = n;
      while (cnt > 1) begin
        ncnt = 0;
        for (int i = 0; i + 1 < cnt; i += 2) begin
          left_of[tasks] = 5'(lvl[i]);
          right_of[tasks] = 5'(lvl[i+1]);
          out_of[tasks] = 5'(nodes);
          parent_of[lvl[i]] = 6'(tasks);
          parent_of[lvl[i+1]] = 6'(tasks);
          nxt[ncnt++] = nodes;
          nodes++;
          tasks++;
        end
        if (cnt % 2 == 1) nxt[ncnt++] = lvl[cnt-1];
        for (int i = 0; i < ncnt; i++) lvl[i] = nxt[i];
        cnt = ncnt;
      end
      root_node = 6'(lvl[0]);
      if (tasks > 0) root_task = tasks - 1;
    endfunction

    // note an accepted command and queue its expected result
    function void note_command(rtt_in_t c);
      rtt_out_t r;
      int id, o;
      r = '0;
      id = int'(c.item_id);
      case (c.cmd)
        CMD_MARK: begin
          if (id >= nodes) r.status = ST_BAD_ID;
          else begin
            ready_bit[id] = 1;
            ready_at[id] = c.event_time;
            if (tasks == 0 && id == root_node && !finished) finish_tree(c.event_time);
            else try_queue(parent_of[id]);
          end
        end
        CMD_POP: begin
          if (fill == 0) r.status = ST_EMPTY;
          else begin
            if (fifo[head] == STOP_TOKEN) r.pop_kind = KIND_STOP;
            else begin
              r.pop_kind = KIND_TASK;
              r.popped_task = fifo[head][3:0];
            end
            head = (head + 1) % NODES;
            fill--;
          end
        end
        CMD_CLAIM: begin
          if (id >= tasks) r.status = ST_BAD_ID;
          else if ((flags[id] & (FLAG_CLAIMED | FLAG_DONE)) != 0 ||
                   (flags[id] & FLAG_QUEUED) == 0 ||
                   !ready_bit[left_of[id]] || !ready_bit[right_of[id]])
            r.status = ST_REFUSED;
          else begin
            flags[id] = (flags[id] | FLAG_CLAIMED) & ~FLAG_QUEUED;
            r.left_time = ready_at[left_of[id]];
            r.right_time = ready_at[right_of[id]];
          end
        end
        CMD_FINISH: begin
          if (id >= tasks) r.status = ST_BAD_ID;
          else begin
            o = int'(out_of[id]);
            flags[id] |= FLAG_DONE;
            ready_bit[o] = 1;
            ready_at[o] = c.event_time;
            if (id == root_task && !finished) finish_tree(c.event_time);
            else try_queue(parent_of[o]);
          end
        end
        CMD_REBUILD: build_tree();
        default: r.status = ST_REFUSED;
      endcase
      r.tree_done = finished;
      r.done_time = finished_at;
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(rtt_out_t got);
      rtt_out_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.pop_kind !== e.pop_kind) begin
        $error("pop_kind exp %0d got %0d", e.pop_kind, got.pop_kind); errors++;
      end
      if (got.popped_task !== e.popped_task) begin
        $error("popped_task exp %0d got %0d", e.popped_task, got.popped_task); errors++;
      end
      if (got.left_time !== e.left_time) begin
        $error("left_time exp %0h got %0h", e.left_time, got.left_time); errors++;
      end
      if (got.right_time !== e.right_time) begin
        $error("right_time exp %0h got %0h", e.right_time, got.right_time); errors++;
      end
      if (got.tree_done !== e.tree_done) begin
        $error("tree_done exp %0d got %0d", e.tree_done, got.tree_done); errors++;
      end
      if (got.done_time !== e.done_time) begin
        $error("done_time exp %0h got %0h", e.done_time, got.done_time); errors++;
      end
    endfunction
  endclass

  logic       clk = 0;
  logic       rst_n = 0;
  logic       in_valid = 0;
  logic       in_ready;
  rtt_in_t    in_data = '0;
  logic       out_valid;
  logic       out_ready = 0;
  rtt_out_t   out_data;
  logic       cfg_wr_en = 0;
  logic [4:0] cfg_wr_data = '0;
  bit         stim_done = 0;

  tracker_board board = new();

  always #4 clk = ~clk;

  reduction_tree_task_tracker_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // random time with all bits exercised, occasionally the extremes
  function automatic logic [TIME_BITS-1:0] rand_time();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return TIME_BITS'({$urandom(), $urandom()});
    endcase
  endfunction

  // valid drops only when a gap follows, so back-to-back beats keep it high
  task automatic send(logic [2:0] cmd, logic [4:0] id, logic [TIME_BITS-1:0] tm);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{cmd: cmd, item_id: id, event_time: tm};
    do @(posedge clk); while (!in_ready);
    board.note_command(in_data);
  endtask

  task automatic drain_idle();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic set_workers(logic [4:0] n);
    drain_idle();
    cfg_wr_en <= 1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en <= 0;
    board.leaves_cfg = n;
  endtask

  // one well-formed reduction with random noise mixed in
  task automatic run_tree();
    int marks[$];
    int n, k;
    logic [2:0] c;
    logic [3:0] p;
    send(CMD_REBUILD, 5'($urandom()), rand_time());
    n = board.leaves();
    for (int i = 0; i < n; i++) marks.insert(marks.size(), i);
    marks.shuffle();
    foreach (marks[i]) send(CMD_MARK, 5'(marks[i]), rand_time());
    k = 0;
    while (!board.finished && k < 200) begin
      k++;
      if ($urandom_range(0, 9) == 0) begin
        // noise that neither steals a queued task nor rebuilds the tree
        c = 3'($urandom_range(0, 7));
        if (c == CMD_POP || c == CMD_REBUILD) c = CMD_CLAIM;
        send(c, 5'($urandom()), rand_time());
      end else begin
        send(CMD_POP, 5'($urandom()), rand_time());
        if (board.pending[$].pop_kind == KIND_TASK) begin
          p = board.pending[$].popped_task;
          send(CMD_CLAIM, {1'b0, p}, rand_time());
          if ($urandom_range(0, 7) == 0) send(CMD_CLAIM, {1'b0, p}, '0);
          send(CMD_FINISH, {1'b0, p}, rand_time());
        end
      end
    end
    for (int i = 0; i < n + 2; i++) send(CMD_POP, '0, '0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
    out_ready <= ($urandom_range(0, 99) < 70) || stim_done;
  end

  initial begin
    int sizes[$];
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // empty tree: ids out of range, queue empty, unknown commands refused
    send(CMD_MARK, 5'd0, '1);
    send(CMD_POP, 5'd31, '0);
    send(CMD_CLAIM, 5'd0, '0);
    send(CMD_FINISH, 5'd31, '1);
    send(CMD_RSVD5, '0, '0);
    send(CMD_RSVD6, 5'd31, '1);
    send(CMD_RSVD7, '0, '0);
    // default 16 leaves: bad ids, premature claim, root mark
    send(CMD_REBUILD, '0, '0);
    send(CMD_MARK, 5'd31, '1);
    send(CMD_MARK, 5'd30, '1);
    send(CMD_CLAIM, 5'd14, '0);
    send(CMD_CLAIM, 5'd15, '0);
    send(CMD_FINISH, 5'd15, '0);
    send(CMD_MARK, 5'd0, '1);
    send(CMD_MARK, 5'd1, '0);
    send(CMD_POP, '0, '0);
    send(CMD_CLAIM, 5'd0, '0);
    send(CMD_CLAIM, 5'd0, '0);
    send(CMD_FINISH, 5'd3, '1);
    send(CMD_FINISH, 5'd14, 48'h5555_aaaa_5555);
    send(CMD_FINISH, 5'd14, 48'h1);
    for (int i = 0; i < 4; i++) send(CMD_POP, '0, '0);
    set_workers(5'd0);
    send(CMD_REBUILD, '0, '0);
    send(CMD_MARK, '0, '0);
    sizes = '{1, 2, 3, 16, 31, 17, 5, 7};
    foreach (sizes[i]) begin
      set_workers(5'(sizes[i]));
      run_tree();
    end
    for (int r = 0; r < 25; r++) begin
      set_workers(5'($urandom_range(0, 99) < 15 ? $urandom_range(0, 31) :
                                                  $urandom_range(1, 9)));
      run_tree();
    end
    stim_done = 1;
    drain_idle();
    if (board.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
